// ----- rtl/core/kca_pkg.sv -----
// ----------------------------------------------------------------------------
// kca_pkg
// shared types, constants and the key table for the keypad click / repeat block
// ----------------------------------------------------------------------------
package kca_pkg;

  // sizing
  localparam int NUM_KEYS   = 18;   // table positions scanned for clicks (1..32)
  localparam int RUN_WIDTH  = 16;   // usb run counter width (4..32)
  localparam int KEY_IDX_W  = 5;
  localparam int KEY_W      = 32;
  localparam int TICK_W     = 32;
  localparam int DELAY_W    = 16;
  localparam int LEN_W      = 16;

  // usb power sense position inside the second key word
  localparam int USB_SENSE_POS = 28;

  // reset values of the delay registers
  localparam logic [DELAY_W-1:0] FIRST_DELAY_RST = 16'd500;
  localparam logic [DELAY_W-1:0] NEXT_DELAY_RST  = 16'd175;

  // configuration register indexes
  localparam logic CFG_FIRST_DELAY = 1'b0;
  localparam logic CFG_NEXT_DELAY  = 1'b1;

  // command codes
  localparam logic CMD_SCAN   = 1'b0;
  localparam logic CMD_FORGET = 1'b1;

  // key word selector
  localparam logic GRP_1 = 1'b0;
  localparam logic GRP_2 = 1'b1;

  typedef struct packed {
    logic             grp;
    logic [KEY_W-1:0] mask;
  } key_entry_t;

  // key table, positions past the list have an empty mask
  function automatic key_entry_t key_lookup(input logic [KEY_IDX_W-1:0] idx);
    key_entry_t e;
    e.grp  = GRP_1;
    e.mask = '0;
    case (idx)
      5'd0:  begin e.grp = GRP_1; e.mask = 32'h0080_0000; end
      5'd1:  begin e.grp = GRP_1; e.mask = 32'h0300_0000; end
      5'd2:  begin e.grp = GRP_1; e.mask = 32'h0200_0000; end
      5'd3:  begin e.grp = GRP_1; e.mask = 32'h0100_0000; end
      5'd4:  begin e.grp = GRP_1; e.mask = 32'h0400_0000; end
      5'd5:  begin e.grp = GRP_1; e.mask = 32'h0800_0000; end
      5'd6:  begin e.grp = GRP_1; e.mask = 32'h1000_0000; end
      5'd7:  begin e.grp = GRP_1; e.mask = 32'h6000_0000; end
      5'd8:  begin e.grp = GRP_1; e.mask = 32'h0040_0000; end
      5'd9:  begin e.grp = GRP_1; e.mask = 32'h0080_0000; end
      5'd10: begin e.grp = GRP_2; e.mask = 32'h0000_0020; end
      5'd11: begin e.grp = GRP_2; e.mask = 32'h0000_0040; end
      5'd12: begin e.grp = GRP_2; e.mask = 32'h0000_0080; end
      5'd13: begin e.grp = GRP_2; e.mask = 32'h0000_0100; end
      5'd14: begin e.grp = GRP_2; e.mask = 32'h0000_0200; end
      5'd15: begin e.grp = GRP_2; e.mask = 32'h0000_0400; end
      5'd16: begin e.grp = GRP_2; e.mask = 32'h0000_0800; end
      5'd17: begin e.grp = GRP_2; e.mask = 32'h0000_1000; end
      default: begin e.grp = GRP_1; e.mask = '0; end
    endcase
    return e;
  endfunction

endpackage

// ----- rtl/core/kca_if.sv -----
// ----------------------------------------------------------------------------
// kca_in_if / kca_out_if
// valid/ready channels for scan items and result items
// ----------------------------------------------------------------------------
interface kca_in_if
  import kca_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [KEY_W-1:0]  keys_group1;
  logic [KEY_W-1:0]  keys_group2;
  logic [TICK_W-1:0] tick;

  modport source (output valid, command, keys_group1, keys_group2, tick, input ready);
  modport sink   (input valid, command, keys_group1, keys_group2, tick, output ready);
endinterface

interface kca_out_if
  import kca_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic                 key_event;
  logic [KEY_IDX_W-1:0] key_index;
  logic                 usb_level;
  logic                 usb_pulse_done;
  logic [LEN_W-1:0]     usb_pulse_len;

  modport source (output valid, key_event, key_index, usb_level, usb_pulse_done,
                  usb_pulse_len, input ready);
  modport sink   (input valid, key_event, key_index, usb_level, usb_pulse_done,
                  usb_pulse_len, output ready);
endinterface

// ----- rtl/core/keypad_click_autorepeat.sv -----
// ----------------------------------------------------------------------------
// keypad_click_autorepeat
// keypad click detector with typematic repeat and usb sense pulse meter
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        command, keys_group1, keys_group2, tick
//  out_ch    out  valid/ready        key_event, key_index, usb_level,
//                                    usb_pulse_done, usb_pulse_len
//  cfg_*     in   cfg_we (no wait)   cfg_idx, cfg_wdata
//
//  one item per cycle sustained while out_ch keeps taking results; an accepted
//  item sits in the input register, then goes through the click/repeat logic
//  into the result register
//  rst_n is synchronous and active low; it empties both registers, sets both
//  key words to all ones, clears repeat and usb state and loads the delays
//  a stalled result holds the result register; the input register still
//  takes one more item, then in_ch.ready drops until the result moves
//
module keypad_click_autorepeat
  import kca_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  kca_in_if.sink             in_ch,
  kca_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic               cfg_idx,
  input  logic [DELAY_W-1:0] cfg_wdata
);

  localparam logic [RUN_WIDTH-1:0] RUN_MAX = '1;

  // configuration
  logic [DELAY_W-1:0] first_delay_r;
  logic [DELAY_W-1:0] next_delay_r;

  // input register
  logic              stg_v_r;
  logic              stg_cmd_r;
  logic [KEY_W-1:0]  stg_g1_r;
  logic [KEY_W-1:0]  stg_g2_r;
  logic [TICK_W-1:0] stg_tick_r;

  // block state
  logic [KEY_W-1:0]     prev_keys_r [2];
  logic [KEY_W-1:0]     cur_keys_r  [2];
  logic [KEY_IDX_W-1:0] rpt_key_r,  rpt_key_nxt;
  logic                 rpt_act_r,  rpt_act_nxt;
  logic [TICK_W-1:0]    rpt_time_r, rpt_time_nxt;
  logic                 rpt_once_r, rpt_once_nxt;
  logic [RUN_WIDTH-1:0] usb_run_r,  usb_run_nxt;

  // result register
  logic                 out_v_r;
  logic                 ev_r,    ev_nxt;
  logic [KEY_IDX_W-1:0] idx_r,   idx_nxt;
  logic                 lvl_r,   lvl_nxt;
  logic                 done_r,  done_nxt;
  logic [LEN_W-1:0]     len_r,   len_nxt;

  logic advance;
  logic is_scan;

  // the staged item moves into the result register when that register is free
  assign advance     = stg_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !stg_v_r || advance;
  assign is_scan     = (stg_cmd_r == CMD_SCAN);

  // ---------------- click / repeat / usb logic ----------------
  logic [KEY_W-1:0]     new_g [2];
  logic [NUM_KEYS-1:0]  clicked;
  logic                 found;
  logic [KEY_IDX_W-1:0] found_idx;
  key_entry_t           rpt_ent;
  logic                 rpt_pressed;
  logic [TICK_W-1:0]    elapsed;
  logic [DELAY_W-1:0]   cur_delay;
  logic                 rpt_fire;
  logic                 new_lvl;
  logic [31:0]          run_ext;

  assign new_g[0] = stg_g1_r;
  assign new_g[1] = stg_g2_r;

  // per-key edge from not fully pressed to fully pressed
  always_comb begin
    key_entry_t e;
    for (int i = 0; i < NUM_KEYS; i++) begin
      e = key_lookup(KEY_IDX_W'(i));
      clicked[i] = ((cur_keys_r[e.grp] & e.mask) != '0) && ((new_g[e.grp] & e.mask) == '0);
    end
  end

  // lowest table position wins
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (clicked[i]) begin
        found     = 1'b1;
        found_idx = KEY_IDX_W'(i);
      end
    end
  end

  assign rpt_ent     = key_lookup(rpt_key_r);
  assign rpt_pressed = (new_g[rpt_ent.grp] & rpt_ent.mask) == '0;
  assign elapsed     = stg_tick_r - rpt_time_r;
  assign cur_delay   = rpt_once_r ? next_delay_r : first_delay_r;
  // backwards stamps (negative difference) never fire
  assign rpt_fire    = !elapsed[TICK_W-1] && (elapsed > TICK_W'(cur_delay));
  assign new_lvl     = stg_g2_r[USB_SENSE_POS];
  assign run_ext     = 32'(usb_run_r);

  always_comb begin
    rpt_key_nxt  = rpt_key_r;
    rpt_act_nxt  = rpt_act_r;
    rpt_time_nxt = rpt_time_r;
    rpt_once_nxt = rpt_once_r;
    usb_run_nxt  = usb_run_r;
    ev_nxt       = 1'b0;
    idx_nxt      = '0;
    lvl_nxt      = cur_keys_r[1][USB_SENSE_POS];
    done_nxt     = 1'b0;
    len_nxt      = '0;
    if (!is_scan) begin
      // forget: only the repeat key is dropped
      rpt_act_nxt = 1'b0;
    end else begin
      lvl_nxt = new_lvl;
      // usb high-run meter
      if (new_lvl) begin
        if (usb_run_r != RUN_MAX) begin
          usb_run_nxt = usb_run_r + 1'b1;
        end
      end else if (usb_run_r != '0) begin
        done_nxt    = 1'b1;
        len_nxt     = (run_ext > 32'h0000_FFFF) ? '1 : run_ext[LEN_W-1:0];
        usb_run_nxt = '0;
      end
      // fresh click takes priority over a repeat
      if (found) begin
        rpt_key_nxt  = found_idx;
        rpt_act_nxt  = 1'b1;
        rpt_once_nxt = 1'b0;
        rpt_time_nxt = stg_tick_r;
        ev_nxt       = 1'b1;
        idx_nxt      = found_idx;
      end else if (rpt_act_r && rpt_pressed) begin
        if (rpt_fire) begin
          rpt_once_nxt = 1'b1;
          rpt_time_nxt = stg_tick_r;
          ev_nxt       = 1'b1;
          idx_nxt      = rpt_key_r;
        end
      end else begin
        // held key let go
        rpt_act_nxt = 1'b0;
      end
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_delay_r <= FIRST_DELAY_RST;
      next_delay_r  <= NEXT_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_FIRST_DELAY: first_delay_r <= cfg_wdata;
        CFG_NEXT_DELAY:  next_delay_r  <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stg_cmd_r  <= in_ch.command;
      stg_g1_r   <= in_ch.keys_group1;
      stg_g2_r   <= in_ch.keys_group2;
      stg_tick_r <= in_ch.tick;
    end
  end

  // block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_keys_r[0] <= '1;
      prev_keys_r[1] <= '1;
      cur_keys_r[0]  <= '1;
      cur_keys_r[1]  <= '1;
      rpt_key_r      <= '0;
      rpt_act_r      <= 1'b0;
      rpt_time_r     <= '0;
      rpt_once_r     <= 1'b0;
      usb_run_r      <= '0;
    end else if (advance) begin
      if (is_scan) begin
        prev_keys_r[0] <= cur_keys_r[0];
        prev_keys_r[1] <= cur_keys_r[1];
        cur_keys_r[0]  <= stg_g1_r;
        cur_keys_r[1]  <= stg_g2_r;
      end
      rpt_key_r  <= rpt_key_nxt;
      rpt_act_r  <= rpt_act_nxt;
      rpt_time_r <= rpt_time_nxt;
      rpt_once_r <= rpt_once_nxt;
      usb_run_r  <= usb_run_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ev_r   <= ev_nxt;
      idx_r  <= idx_nxt;
      lvl_r  <= lvl_nxt;
      done_r <= done_nxt;
      len_r  <= len_nxt;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.key_event      = ev_r;
  assign out_ch.key_index      = idx_r;
  assign out_ch.usb_level      = lvl_r;
  assign out_ch.usb_pulse_done = done_r;
  assign out_ch.usb_pulse_len  = len_r;

  // ---------------- assertions ----------------
  // a reported key is always a scanned table position
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && ev_r) |-> (32'(idx_r) < NUM_KEYS))
    else $error("key index out of table range");

  // a finished usb run is reported only while the level is low
  a_done_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && done_r) |-> (!lvl_r && len_r != '0))
    else $error("usb pulse reported while sense high or with zero length");

  // a scan with the sense high leaves a nonzero run count
  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_scan && new_lvl) |=> (usb_run_r != '0))
    else $error("usb run count not advanced");

  // a forget command always drops the repeat key
  a_forget: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !is_scan) |=> !rpt_act_r)
    else $error("repeat key survived forget command");

  // input is held off only while the input register is full and stuck
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (stg_v_r && out_v_r && !out_ch.ready))
    else $error("input stalled without a blocked result");

endmodule

// ----- verif/tb_keypad_click_autorepeat.sv -----
// ----------------------------------------------------------------------------
// tb_keypad_click_autorepeat
// self-checking bench for the keypad click / typematic repeat / usb meter block
//
// scan items and forget commands go in over a valid/ready channel.
// A tracker class mirrors the key words, the repeat timer and the usb run
// counter, and queues one expected result per accepted item. Every result
// item is compared field by field against the oldest entry. Directed scans
// cover clicks, repeats on both delays, tick wrap, backward stamps and the
// forget command. Random key-hold sequences follow under several delay and
// idle/stall settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import kca_pkg::*;

// key positions as the block scans them, index 0 on the left
localparam logic [0:17][KEY_W-1:0] KEY_MASK_TBL = '{
  32'h0080_0000, 32'h0300_0000, 32'h0200_0000, 32'h0100_0000,
  32'h0400_0000, 32'h0800_0000, 32'h1000_0000, 32'h6000_0000,
  32'h0040_0000, 32'h0080_0000,
  32'h0000_0020, 32'h0000_0040, 32'h0000_0080, 32'h0000_0100,
  32'h0000_0200, 32'h0000_0400, 32'h0000_0800, 32'h0000_1000
};
localparam logic [0:17] KEY_GRP_TBL = 18'b0000000000_11111111;
localparam int TBL_KEYS = 18;

function automatic logic [KEY_W-1:0] key_mask(input int idx);
  if (idx < TBL_KEYS) return KEY_MASK_TBL[idx];
  return '0;
endfunction

function automatic logic key_grp(input int idx);
  if (idx < TBL_KEYS) return KEY_GRP_TBL[idx];
  return GRP_1;
endfunction

typedef struct packed {
  logic              command;
  logic [KEY_W-1:0]  keys_group1;
  logic [KEY_W-1:0]  keys_group2;
  logic [TICK_W-1:0] tick;
} kca_scan_t;

typedef struct packed {
  logic                 key_event;
  logic [KEY_IDX_W-1:0] key_index;
  logic                 usb_level;
  logic                 usb_pulse_done;
  logic [LEN_W-1:0]     usb_pulse_len;
} kca_result_t;

class click_repeat_tracker;
  kca_result_t          due_results[$];
  int                   errors;
  int                   scans;
  int                   forgets;
  int                   clicks;
  int                   repeats;
  int                   pulses;
  int                   longest;
  logic [DELAY_W-1:0]   first_dly;
  logic [DELAY_W-1:0]   next_dly;
  logic [KEY_W-1:0]     prev_w[2];
  logic [KEY_W-1:0]     cur_w[2];
  logic [KEY_IDX_W-1:0] rpt_key;
  bit                   rpt_active;
  logic [TICK_W-1:0]    rpt_time;
  bit                   rpt_once;
  int unsigned          usb_run;

  function new();
    first_dly  = FIRST_DELAY_RST;
    next_dly   = NEXT_DELAY_RST;
    prev_w[0]  = '1;
    prev_w[1]  = '1;
    cur_w[0]   = '1;
    cur_w[1]   = '1;
    rpt_key    = '0;
    rpt_active = 0;
    rpt_time   = '0;
    rpt_once   = 0;
    usb_run    = 0;
  endfunction

  function void set_delay(input logic idx, input logic [DELAY_W-1:0] val);
    if (idx == CFG_FIRST_DELAY) first_dly = val;
    else next_dly = val;
  endfunction

  function int pending();
    return due_results.size();
  endfunction

  function void note_scan(input kca_scan_t s);
    kca_result_t      r;
    logic [KEY_W-1:0] m;
    logic             g;
    logic [31:0]      d;
    logic [31:0]      dly;
    int unsigned      run_max;
    bit               found;
    r = '0;
    run_max = 32'hFFFF_FFFF >> (32 - RUN_WIDTH);
    if (s.command == CMD_FORGET) begin
      rpt_active = 0;
      forgets++;
    end else begin
      scans++;
      prev_w[0] = cur_w[0];
      prev_w[1] = cur_w[1];
      cur_w[0]  = s.keys_group1;
      cur_w[1]  = s.keys_group2;
      if (cur_w[1][USB_SENSE_POS]) begin
        if (usb_run < run_max) usb_run++;
      end else if (usb_run != 0) begin
        r.usb_pulse_done = 1'b1;
        r.usb_pulse_len  = (usb_run > 32'hFFFF) ? 16'hFFFF : usb_run[LEN_W-1:0];
        pulses++;
        if (usb_run > longest) longest = int'(usb_run);
        usb_run = 0;
      end
      found = 0;
      for (int i = 0; i < NUM_KEYS && !found; i++) begin
        m = key_mask(i);
        g = key_grp(i);
        if ((prev_w[g] & m) != 0 && (cur_w[g] & m) == 0) begin
          found      = 1;
          rpt_key    = KEY_IDX_W'(i);
          rpt_active = 1;
          rpt_once   = 0;
          rpt_time   = s.tick;
          r.key_event = 1'b1;
          r.key_index = KEY_IDX_W'(i);
          clicks++;
        end
      end
      if (!found) begin
        m = key_mask(rpt_key);
        g = key_grp(rpt_key);
        if (rpt_active && (cur_w[g] & m) == 0) begin
          d   = s.tick - rpt_time;
          dly = 32'(rpt_once ? next_dly : first_dly);
          // backward stamps read as negative and never fire
          if (!d[31] && d > dly) begin
            rpt_once    = 1;
            rpt_time    = s.tick;
            r.key_event = 1'b1;
            r.key_index = rpt_key;
            repeats++;
          end
        end else begin
          rpt_active = 0;
        end
      end
    end
    r.usb_level = cur_w[1][USB_SENSE_POS];
    due_results.push_back(r);
  endfunction

  function void check_result(input kca_result_t got);
    kca_result_t want;
    if (due_results.size() == 0) begin
      errors++;
      $error("result item arrived with nothing pending");
      return;
    end
    want = due_results.pop_front();
    if (got.key_event !== want.key_event) begin
      errors++;
      $error("key_event mismatch: expected %0d, actual %0d", want.key_event, got.key_event);
    end
    if (got.key_index !== want.key_index) begin
      errors++;
      $error("key_index mismatch: expected %0d, actual %0d", want.key_index, got.key_index);
    end
    if (got.usb_level !== want.usb_level) begin
      errors++;
      $error("usb_level mismatch: expected %0d, actual %0d", want.usb_level, got.usb_level);
    end
    if (got.usb_pulse_done !== want.usb_pulse_done) begin
      errors++;
      $error("usb_pulse_done mismatch: expected %0d, actual %0d",
             want.usb_pulse_done, got.usb_pulse_done);
    end
    if (got.usb_pulse_len !== want.usb_pulse_len) begin
      errors++;
      $error("usb_pulse_len mismatch: expected %0d, actual %0d",
             want.usb_pulse_len, got.usb_pulse_len);
    end
  endfunction
endclass

module tb_keypad_click_autorepeat;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_idx;
  logic [DELAY_W-1:0] cfg_wdata;

  kca_in_if  in_ch();
  kca_out_if out_ch();

  keypad_click_autorepeat dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  click_repeat_tracker tracker = new();

  // idle / stall knobs shared between the main sequence and the receiver
  int src_idle_pct    = 0;
  int snk_stall_pct   = 0;
  int hold_off_cycles = 0;
  int items_sent      = 0;
  int settings_used   = 0;

  // virtual keypad the random sequences play on
  logic [KEY_W-1:0]   kb_g1;
  logic [KEY_W-1:0]   kb_g2;
  logic [TICK_W-1:0]  kb_tick;
  logic               kb_usb;
  logic [DELAY_W-1:0] cur_first;
  logic [DELAY_W-1:0] cur_next;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // result side: check what was taken at this edge, then pick next ready
  initial begin
    kca_result_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.key_event      = out_ch.key_event;
        got.key_index      = out_ch.key_index;
        got.usb_level      = out_ch.usb_level;
        got.usb_pulse_done = out_ch.usb_pulse_done;
        got.usb_pulse_len  = out_ch.usb_pulse_len;
        tracker.check_result(got);
      end
      if (hold_off_cycles > 0) begin
        // long hold-off so both internal registers fill and in_ch stalls
        out_ch.ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // offer one item, with random idle cycles ahead of it, until taken;
  // valid stays high on return so back-to-back items need no toggle
  task automatic send_item(input kca_scan_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= it.command;
    in_ch.keys_group1 <= it.keys_group1;
    in_ch.keys_group2 <= it.keys_group2;
    in_ch.tick        <= it.tick;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_scan(it);
    items_sent++;
  endtask

  task automatic send_scan(input logic [KEY_W-1:0] g1, input logic [KEY_W-1:0] g2,
                           input logic [TICK_W-1:0] t);
    kca_scan_t it;
    it.command     = CMD_SCAN;
    it.keys_group1 = g1;
    it.keys_group2 = g2;
    it.tick        = t;
    send_item(it);
  endtask

  // forget command, payload is don't-care so it carries noise
  task automatic forget_key();
    kca_scan_t it;
    it.command     = CMD_FORGET;
    it.keys_group1 = $urandom;
    it.keys_group2 = $urandom;
    it.tick        = $urandom;
    send_item(it);
  endtask

  task automatic write_reg(input logic idx, input logic [DELAY_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    tracker.set_delay(idx, val);
    if (idx == CFG_FIRST_DELAY) cur_first = val;
    else cur_next = val;
  endtask

  // stop offering, wait for every result and any hold-off, then idle on the clock
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (tracker.pending() > 0 || hold_off_cycles > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // tick advance scaled to the active delays, with boundary hits and jumps
  function automatic logic [TICK_W-1:0] tick_step();
    int unsigned r;
    int unsigned dmax;
    r    = $urandom_range(99);
    dmax = (cur_first > cur_next) ? cur_first : cur_next;
    if (r < 8) return '0;
    if (r < 16) return $urandom_range(1, 3);
    if (r < 76) return $urandom_range(0, dmax + dmax / 2 + 2);
    if (r < 90) return (r[0] ? cur_first : cur_next) + $urandom_range(0, 1);
    return $urandom;
  endfunction

  task automatic press_key(input int k);
    if (key_grp(k) == GRP_2) kb_g2 &= ~key_mask(k);
    else kb_g1 &= ~key_mask(k);
  endtask

  task automatic scan_kb();
    if ($urandom_range(99) < 12) kb_usb = ~kb_usb;
    kb_tick = kb_tick + tick_step();
    kb_g2[USB_SENSE_POS] = kb_usb;
    send_scan(kb_g1, kb_g2, kb_tick);
  endtask

  // mostly press-and-hold sequences, the rest noise and broken sequences
  task automatic run_random(input int n, input bit with_hold_off);
    int               stop;
    int               half;
    int               k;
    int               c;
    int               len;
    logic [KEY_W-1:0] m;
    stop = items_sent + n;
    half = items_sent + n / 2;
    while (items_sent < stop) begin
      if (with_hold_off && items_sent >= half) begin
        hold_off_cycles = 240;
        with_hold_off   = 0;
      end
      c = $urandom_range(99);
      if (c < 60) begin
        k = $urandom_range(TBL_KEYS - 1);
        if ($urandom_range(9) != 0) begin
          // release everything, noise only on bits no key uses
          kb_g1 = 32'hFFFF_FFFF ^ ($urandom & 32'h803F_FFFF);
          kb_g2 = 32'hFFFF_FFFF ^ ($urandom & 32'hEFFF_E01F);
          scan_kb();
        end
        press_key(k);
        scan_kb();
        len = $urandom_range(1, 12);
        repeat (len) begin
          c = $urandom_range(99);
          if (c < 8) begin
            forget_key();
          end else begin
            if (c < 16) begin
              press_key($urandom_range(TBL_KEYS - 1));
            end else if (c < 21) begin
              // let go of one bit of the held key
              m = key_mask(k);
              m = m & (~m + 1);
              if (key_grp(k) == GRP_2) kb_g2 |= m;
              else kb_g1 |= m;
            end
            scan_kb();
          end
        end
      end else if (c < 80) begin
        if ($urandom_range(3) == 0) forget_key();
        else send_scan($urandom, $urandom, $urandom);
      end else begin
        case ($urandom_range(3))
          0: begin
            // half-pressed two-switch key
            kb_g1 = 32'hFFFF_FFFF;
            scan_kb();
            k = $urandom_range(1) ? 1 : 7;
            m = key_mask(k);
            kb_g1 &= ~(m & (~m + 1));
            scan_kb();
          end
          1: begin
            kb_tick = kb_tick - $urandom_range(1, 2000);
            send_scan(kb_g1, kb_g2, kb_tick);
          end
          2: forget_key();
          default: begin
            kb_g1 = 32'hFFFF_FFFF;
            kb_g2 = 32'hFFFF_FFFF;
            scan_kb();
          end
        endcase
      end
    end
  endtask

  initial begin
    logic [DELAY_W-1:0] f;
    logic [DELAY_W-1:0] n;
    // every input known from time zero
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_FIRST_DELAY;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.command     <= CMD_SCAN;
    in_ch.keys_group1 <= '1;
    in_ch.keys_group2 <= '1;
    in_ch.tick        <= '0;
    cur_first = FIRST_DELAY_RST;
    cur_next  = NEXT_DELAY_RST;
    kb_g1     = '1;
    kb_g2     = '1;
    kb_tick   = '0;
    kb_usb    = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset delays 500 / 175
    send_scan(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_scan(32'h0, 32'h0, 32'd10);             // click key 0, usb run ends
    send_scan(32'h0, 32'h0, 32'd400);            // still under first delay
    send_scan(32'h0, 32'h0, 32'd511);            // first repeat
    send_scan(32'h0, 32'h0, 32'd687);            // one past next delay
    send_scan(32'h0, 32'h0, 32'd862);            // exactly next delay, no fire
    forget_key();
    send_scan(32'h0, 32'h0, 32'd5000);           // forgotten, held key is silent
    send_scan(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5001);
    send_scan(32'hFFFF_FFFF, 32'hFFFF_EFFF, 32'hFFFF_FF00); // click key 17
    send_scan(32'hFFFF_FFFF, 32'hFFFF_EFFF, 32'h0000_0100); // repeat across wrap
    send_scan(32'hFFFF_FFFF, 32'hFFFF_EFFF, 32'h0000_0100 - 32'd1000); // backward
    send_scan(32'hFFFF_FFFF, 32'hFFFF_EFFF, 32'h8000_0100); // half range, negative
    send_scan(32'hFFFF_FFFF, 32'hFFFF_EFFF, 32'h8000_00FF); // largest positive
    send_scan(32'hDFFF_FFFF, 32'hEFFF_FFFF, 32'h8000_0200); // release, half press
    send_scan(32'h9FFF_FFFF, 32'hEFFF_FFFF, 32'h8000_0300); // two-switch click
    send_scan(32'h0, 32'hEFFF_FFFF, 32'h8000_0400);         // first match wins
    forget_key();

    // directed, zero delays
    wait_results_drained();
    write_reg(CFG_FIRST_DELAY, 16'd0);
    write_reg(CFG_NEXT_DELAY, 16'd0);
    settings_used++;
    send_scan(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd100);
    send_scan(32'hFFFF_FFFF, 32'hFFFF_FFDF, 32'd100);  // click key 10
    send_scan(32'hFFFF_FFFF, 32'hFFFF_FFDF, 32'd100);  // zero elapsed, no fire
    send_scan(32'hFFFF_FFFF, 32'hFFFF_FFDF, 32'd101);
    send_scan(32'hFFFF_FFFF, 32'hFFFF_FFDF, 32'd102);

    // directed, largest delays
    wait_results_drained();
    write_reg(CFG_FIRST_DELAY, 16'hFFFF);
    write_reg(CFG_NEXT_DELAY, 16'hFFFF);
    settings_used++;
    send_scan(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_scan(32'hFFFF_FFFF, 32'hFFFF_F7FF, 32'd0);       // click key 16
    send_scan(32'hFFFF_FFFF, 32'hFFFF_F7FF, 32'd65535);
    send_scan(32'hFFFF_FFFF, 32'hFFFF_F7FF, 32'd65536);
    send_scan(32'hFFFF_FFFF, 32'hFFFF_F7FF, 32'd131072);

    // random phases, each with its own delays and one of four idle/stall patterns
    for (int p = 0; p < 6; p++) begin
      wait_results_drained();
      case (p)
        0: begin f = FIRST_DELAY_RST; n = NEXT_DELAY_RST; end
        1: begin f = 16'd0;           n = 16'd0;          end
        2: begin f = 16'hFFFF;        n = 16'hFFFF;       end
        3: begin
          f = DELAY_W'($urandom_range(1, 60));
          n = DELAY_W'($urandom_range(1, 60));
        end
        4: begin f = 16'hFFFF;        n = 16'd0;          end
        default: begin f = 16'd0;     n = 16'hFFFF;       end
      endcase
      write_reg(CFG_FIRST_DELAY, f);
      write_reg(CFG_NEXT_DELAY, n);
      settings_used++;
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 60; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 60; end
        default: begin src_idle_pct = 9; snk_stall_pct = 9; end
      endcase
      run_random(284, p == 0);
    end

    wait_results_drained();
    repeat (8) @(posedge clk);
    $display("ran %0d scans and %0d forget commands over %0d delay settings",
             tracker.scans, tracker.forgets, settings_used);
    $display("saw %0d clicks, %0d repeats and %0d usb pulses, longest run %0d scans",
             tracker.clicks, tracker.repeats, tracker.pulses, tracker.longest);
    if (tracker.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
